// ===== rtl/sbr_pkg.sv =====
package sbr_pkg;

  // Configuration register file
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned TICK_CFG_W   = 16;
  localparam int unsigned TIMEOUT_W    = 20;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [TICK_CFG_W-1:0] RESET_BIT_TICKS      = 16'd104;
  localparam logic [TICK_CFG_W-1:0] RESET_HALF_BIT_TICKS = 16'd52;
  localparam logic                  RESET_IDLE_LEVEL     = 1'b1;
  localparam logic [TIMEOUT_W-1:0]  RESET_TIMEOUT        = 20'd250000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIT_TICKS      = 3'd0,
    CFG_HALF_BIT_TICKS = 3'd1,
    CFG_IDLE_LEVEL     = 3'd2,
    CFG_IDLE_TIMEOUT   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TICK_CFG_W-1:0] bit_ticks;
    logic [TICK_CFG_W-1:0] half_bit_ticks;
    logic                  idle_level;
    logic [TIMEOUT_W-1:0]  idle_timeout_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_BYTE        = 2'd0,
    ST_TIMEOUT     = 2'd1,
    ST_FALSE_START = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/sbr_cfg.sv =====
module sbr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sbr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sbr_pkg::cfg_t                     cfg
);

  sbr_pkg::cfg_t cfg_r;
  sbr_pkg::cfg_t cfg_nxt;

  // Writes are always accepted and registered
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sbr_pkg::CFG_BIT_TICKS:
          cfg_nxt.bit_ticks = cfg_data[sbr_pkg::TICK_CFG_W-1:0];
        sbr_pkg::CFG_HALF_BIT_TICKS:
          cfg_nxt.half_bit_ticks = cfg_data[sbr_pkg::TICK_CFG_W-1:0];
        sbr_pkg::CFG_IDLE_LEVEL:
          cfg_nxt.idle_level = cfg_data[0];
        sbr_pkg::CFG_IDLE_TIMEOUT:
          cfg_nxt.idle_timeout_ticks = cfg_data[sbr_pkg::TIMEOUT_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks          <= sbr_pkg::RESET_BIT_TICKS;
      cfg_r.half_bit_ticks     <= sbr_pkg::RESET_HALF_BIT_TICKS;
      cfg_r.idle_level         <= sbr_pkg::RESET_IDLE_LEVEL;
      cfg_r.idle_timeout_ticks <= sbr_pkg::RESET_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/sbr_core.sv =====
module sbr_core #(
  parameter int unsigned DATA_BITS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sbr_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic             line_level,
  output logic             res_valid,
  output sbr_pkg::result_t res
);

  localparam int unsigned IDX_W = $clog2(DATA_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

  sbr_pkg::phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]          tick_count_r, tick_count_nxt;
  logic [IDX_W-1:0]                bit_index_r, bit_index_nxt;
  logic [DATA_BITS-1:0]            shift_byte_r, shift_byte_nxt;
  logic [sbr_pkg::TIMEOUT_W-1:0]   timeout_left_r, timeout_left_nxt;

  logic                   at_idle;
  logic                   expired;
  logic                   data_bit;
  logic [COUNT_WIDTH-1:0] bit_load;
  logic [COUNT_WIDTH-1:0] half_load;

  assign at_idle   = (line_level == cfg.idle_level);
  assign expired   = (tick_count_r <= COUNT_WIDTH'(1));
  assign data_bit  = line_level ^ ~cfg.idle_level;
  assign bit_load  = COUNT_WIDTH'(cfg.bit_ticks);
  assign half_load = COUNT_WIDTH'(cfg.half_bit_ticks);

  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    bit_index_nxt    = bit_index_r;
    shift_byte_nxt   = shift_byte_r;
    timeout_left_nxt = timeout_left_r;
    res_valid        = 1'b0;
    res.data_byte    = '0;
    res.status       = sbr_pkg::ST_BYTE;

    if (step) begin
      if (phase_r != sbr_pkg::PH_IDLE && !expired) begin
        tick_count_nxt = tick_count_r - COUNT_WIDTH'(1);
      end
      unique case (phase_r)
        sbr_pkg::PH_IDLE: begin
          if (at_idle) begin
            if (timeout_left_r <= sbr_pkg::TIMEOUT_W'(1)) begin
              timeout_left_nxt = cfg.idle_timeout_ticks;
              res_valid        = 1'b1;
              res.status       = sbr_pkg::ST_TIMEOUT;
            end else begin
              timeout_left_nxt = timeout_left_r - sbr_pkg::TIMEOUT_W'(1);
            end
          end else begin
            phase_nxt      = sbr_pkg::PH_START;
            tick_count_nxt = half_load;
          end
        end
        sbr_pkg::PH_START: begin
          if (expired) begin
            if (at_idle) begin
              phase_nxt        = sbr_pkg::PH_IDLE;
              timeout_left_nxt = cfg.idle_timeout_ticks;
              res_valid        = 1'b1;
              res.status       = sbr_pkg::ST_FALSE_START;
            end else begin
              phase_nxt      = sbr_pkg::PH_DATA;
              tick_count_nxt = bit_load;
              bit_index_nxt  = '0;
              shift_byte_nxt = '0;
            end
          end
        end
        sbr_pkg::PH_DATA: begin
          if (expired) begin
            shift_byte_nxt              = shift_byte_r;
            shift_byte_nxt[bit_index_r] = shift_byte_r[bit_index_r] | data_bit;
            if (bit_index_r >= LAST_IDX) begin
              phase_nxt = sbr_pkg::PH_STOP;
            end else begin
              bit_index_nxt = bit_index_r + IDX_W'(1);
            end
            tick_count_nxt = bit_load;
          end
        end
        sbr_pkg::PH_STOP: begin
          if (expired) begin
            phase_nxt        = sbr_pkg::PH_IDLE;
            timeout_left_nxt = cfg.idle_timeout_ticks;
            res_valid        = 1'b1;
            res.status       = sbr_pkg::ST_BYTE;
            res.data_byte    = sbr_pkg::BYTE_W'(shift_byte_r);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sbr_pkg::PH_IDLE;
      tick_count_r   <= '0;
      bit_index_r    <= '0;
      shift_byte_r   <= '0;
      timeout_left_r <= sbr_pkg::RESET_TIMEOUT;
    end else begin
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_byte_r   <= shift_byte_nxt;
      timeout_left_r <= timeout_left_nxt;
    end
  end

  // After any reported word the framer sits in idle; a timeout keeps it there
  a_res_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> phase_r == sbr_pkg::PH_IDLE)
    else $error("framer not idle after a reported word");

  // A start edge always loads the half-bit count
  a_start_loads_half: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == sbr_pkg::PH_IDLE && !at_idle) |=>
      (phase_r == sbr_pkg::PH_START && tick_count_r == $past(half_load)))
    else $error("start edge did not load the half-bit count");

endmodule

// ===== rtl/sbr_skid.sv =====
module sbr_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sbr_pkg::result_t push_word,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output sbr_pkg::result_t out_word
);

  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  sbr_pkg::result_t out_w_r, out_w_nxt;
  sbr_pkg::result_t skid_w_r, skid_w_nxt;
  logic             pop;

  assign pop      = out_v_r & out_ready;
  assign can_push = ~skid_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_w_nxt  = out_w_r;
    skid_w_nxt = skid_w_r;
    if (!out_v_r || pop) begin
      // advance the older word into the output register
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_w_nxt  = skid_w_r;
        skid_v_nxt = push;
        skid_w_nxt = push_word;
      end else begin
        out_v_nxt = push;
        out_w_nxt = push_word;
      end
    end else if (push) begin
      // hold the new word behind the stalled one
      skid_v_nxt = 1'b1;
      skid_w_nxt = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_w_r  <= out_w_nxt;
    skid_w_r <= skid_w_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_w_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word present with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !pop) |=> (skid_v_r && skid_w_r == $past(skid_w_r)))
    else $error("skid word lost or overwritten");

endmodule

// ===== rtl/serial_byte_receiver.sv =====
// serial_byte_receiver: frames asynchronous 8N1-style bytes from a stream of
// receive-line samples, one sample per word on the in_ channel.
// - in_line_level: one sample per accepted word; a word is normally offered
//   every cycle and is taken whenever in_ready is high.
// - out_data_byte / out_status: one word per received byte (status 0), idle
//   timeout (status 1) or false start (status 2); data_byte is 0 unless a
//   byte was received.
// - cfg_index / cfg_data: register writes, taken every cycle (cfg_ready is
//   tied high). Index 0 bit_ticks, 1 half_bit_ticks, 2 idle_level,
//   3 idle_timeout_ticks; other indexes are dropped.
// Throughput is one sample per cycle while in_ready is high. A result is
// registered in the output register, or in the skid stage while output
// stalls; the framer state, output register and skid stage are the stages.
// Reset (synchronous, active low) restores the register defaults, returns the
// framer to idle with a full idle timeout and empties the output and skid stages.
// Stall: the output register has a one-word skid stage behind it, so sampling
// continues while one result waits. in_ready drops only once both the output
// register and the skid stage hold words.
module serial_byte_receiver #(
  parameter int unsigned DATA_BITS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_line_level,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sbr_pkg::BYTE_W-1:0]      out_data_byte,
  output logic [1:0]                      out_status,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sbr_pkg::cfg_t    cfg;
  sbr_pkg::result_t res;
  sbr_pkg::result_t out_word;
  logic             res_valid;
  logic             in_fire;

  // advance the framer only on an accepted sample
  assign in_fire = in_valid & in_ready;

  sbr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbr_core #(
    .DATA_BITS   (DATA_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (in_fire),
    .line_level (in_line_level),
    .res_valid  (res_valid),
    .res        (res)
  );

  sbr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_word (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_data_byte = out_word.data_byte;
  assign out_status    = out_word.status;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BITS  = 8;
  localparam int COUNT_BITS  = 16;
  // Extra wait after the last predicted word, allowing for the skid stage.
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_SAMPLES = 1400;
  localparam logic [sbr_pkg::CFG_INDEX_W-1:0] CFG_FIRST_UNUSED =
    sbr_pkg::CFG_INDEX_W'(sbr_pkg::CFG_IDLE_TIMEOUT + 1);
  localparam logic [sbr_pkg::CFG_INDEX_W-1:0] CFG_LAST_UNUSED  = '1;

  // Predicts framer words from accepted line samples and checks them.
  class rx_scoreboard;
    logic [sbr_pkg::TICK_CFG_W-1:0] bit_ticks;
    logic [sbr_pkg::TICK_CFG_W-1:0] half_ticks;
    logic                           idle_lvl;
    logic [sbr_pkg::TIMEOUT_W-1:0]  timeout_ticks;

    sbr_pkg::phase_t                ph;
    logic [COUNT_BITS-1:0]          ticks_left;
    logic [2:0]                     bit_pos;
    logic [sbr_pkg::BYTE_W-1:0]     shift;
    logic [sbr_pkg::TIMEOUT_W-1:0]  idle_left;

    sbr_pkg::result_t               pending[$];
    int                             errors;

    function new();
      bit_ticks     = sbr_pkg::RESET_BIT_TICKS;
      half_ticks    = sbr_pkg::RESET_HALF_BIT_TICKS;
      idle_lvl      = sbr_pkg::RESET_IDLE_LEVEL;
      timeout_ticks = sbr_pkg::RESET_TIMEOUT;
      ph            = sbr_pkg::PH_IDLE;
      ticks_left    = '0;
      bit_pos       = '0;
      shift         = '0;
      idle_left     = sbr_pkg::RESET_TIMEOUT;
      errors        = 0;
    endfunction

    function void apply_reg(logic [sbr_pkg::CFG_INDEX_W-1:0] idx,
                            logic [sbr_pkg::CFG_DATA_W-1:0] val);
      case (sbr_pkg::cfg_reg_t'(idx))
        sbr_pkg::CFG_BIT_TICKS:      bit_ticks     = val[sbr_pkg::TICK_CFG_W-1:0];
        sbr_pkg::CFG_HALF_BIT_TICKS: half_ticks    = val[sbr_pkg::TICK_CFG_W-1:0];
        sbr_pkg::CFG_IDLE_LEVEL:     idle_lvl      = val[0];
        sbr_pkg::CFG_IDLE_TIMEOUT:   timeout_ticks = val[sbr_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    endfunction

    // A count of 0 or 1 expires on this sample; otherwise count down.
    function bit interval_done();
      if (ticks_left <= 1) return 1'b1;
      ticks_left = ticks_left - 1'b1;
      return 1'b0;
    endfunction

    function void back_to_idle();
      ph        = sbr_pkg::PH_IDLE;
      idle_left = timeout_ticks;
    endfunction

    function void queue_word(logic [sbr_pkg::BYTE_W-1:0] data, sbr_pkg::status_t st);
      sbr_pkg::result_t w;
      w.data_byte = data;
      w.status    = st;
      pending.push_back(w);
    endfunction

    function void note_sample(logic lvl);
      logic at_idle;
      logic bit_v;
      at_idle = (lvl == idle_lvl);
      case (ph)
        sbr_pkg::PH_IDLE: begin
          if (!at_idle) begin
            ph         = sbr_pkg::PH_START;
            ticks_left = half_ticks;
          end else if (idle_left <= 1) begin
            idle_left = timeout_ticks;
            queue_word('0, sbr_pkg::ST_TIMEOUT);
          end else begin
            idle_left = idle_left - 1'b1;
          end
        end
        sbr_pkg::PH_START: begin
          if (interval_done()) begin
            if (at_idle) begin
              back_to_idle();
              queue_word('0, sbr_pkg::ST_FALSE_START);
            end else begin
              ph         = sbr_pkg::PH_DATA;
              ticks_left = bit_ticks;
              bit_pos    = '0;
              shift      = '0;
            end
          end
        end
        sbr_pkg::PH_DATA: begin
          if (interval_done()) begin
            bit_v = idle_lvl ? lvl : ~lvl;
            if (bit_v) shift[bit_pos] = 1'b1;
            if (bit_pos == FRAME_BITS - 1) ph = sbr_pkg::PH_STOP;
            else bit_pos = bit_pos + 1'b1;
            ticks_left = bit_ticks;
          end
        end
        default: begin
          // Stop bit level is ignored: emit after one bit time.
          if (interval_done()) begin
            back_to_idle();
            queue_word(shift, sbr_pkg::ST_BYTE);
          end
        end
      endcase
    endfunction

    function void check_word(logic [sbr_pkg::BYTE_W-1:0] data, logic [1:0] st);
      sbr_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("unexpected word: data_byte %02h status %0d", data, st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data !== want.data_byte) begin
        $error("data_byte mismatch: expected %02h, actual %02h", want.data_byte, data);
        errors++;
      end
      if (st !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_line_level = 1'b1;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [sbr_pkg::BYTE_W-1:0]      out_data_byte;
  logic [1:0]                      out_status;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sbr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  rx_scoreboard sb = new();

  // Stimulus bookkeeping: current line setup as the generator sees it.
  int   samples_sent = 0;
  int   calm_left = 0;
  int   ready_run = 0;
  int   ready_hold = 0;
  int   cur_bit;
  int   cur_half;
  logic line_idle;

  serial_byte_receiver #(
    .DATA_BITS   (FRAME_BITS),
    .COUNT_WIDTH (COUNT_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_byte (out_data_byte),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run, long stalls on every word included.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Sample every handshake at the rising edge; the driving side only moves
  // at the falling edge, so nothing here races the block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_word(out_data_byte, out_status);
      if (in_valid && in_ready) sb.note_sample(in_line_level);
      if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
    end
  end

  // Receiver back-pressure: short stalls mostly, a few long ones, and
  // occasional long stretches with out_ready held high.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else begin
      out_ready <= 1'b1;
      ready_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
      ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                               : $urandom_range(1, 3);
    end
  end

  // Gap before the next sample word: mostly back to back, a few long gaps,
  // and now and then a calm stretch with no gaps at all.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(20, 200);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one line sample word and hold it until accepted.
  task automatic send_sample(logic lvl);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_line_level <= lvl;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic send_idle(int n);
    repeat (n) send_sample(line_idle);
  endtask

  // Drive one 8N1 frame laid out around the block's own sample points:
  // start check at half a bit, then one sample per bit time. A cut >= 0
  // truncates the frame after that many samples.
  task automatic send_frame(logic [7:0] data, int cut);
    int   bt;
    int   hf;
    int   total;
    int   seg;
    logic lvl;
    bt    = (cur_bit == 0) ? 1 : cur_bit;
    hf    = (cur_half == 0) ? 1 : cur_half;
    total = hf + 9 * bt + 1;
    if (cut >= 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      seg = (i <= hf) ? 0 : (i - hf + bt - 1) / bt;
      if (seg == 0) lvl = ~line_idle;
      else if (seg == 9) lvl = line_idle;
      else lvl = data[seg-1] ? line_idle : ~line_idle;
      send_sample(lvl);
    end
  endtask

  // Drop valid so the line stream pauses.
  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every predicted word, then let the block settle.
  task automatic drain_results();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [sbr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all four registers and track what the frame generator must use.
  task automatic configure(logic [sbr_pkg::CFG_DATA_W-1:0] bt_word,
                           logic [sbr_pkg::CFG_DATA_W-1:0] hf_word,
                           logic [sbr_pkg::CFG_DATA_W-1:0] lvl_word,
                           logic [sbr_pkg::CFG_DATA_W-1:0] tmo_word);
    write_reg(sbr_pkg::CFG_BIT_TICKS, bt_word);
    write_reg(sbr_pkg::CFG_HALF_BIT_TICKS, hf_word);
    write_reg(sbr_pkg::CFG_IDLE_LEVEL, lvl_word);
    write_reg(sbr_pkg::CFG_IDLE_TIMEOUT, tmo_word);
    cur_bit   = bt_word[sbr_pkg::TICK_CFG_W-1:0];
    cur_half  = hf_word[sbr_pkg::TICK_CFG_W-1:0];
    line_idle = lvl_word[0];
  endtask

  // One random setting: random line timing, idle level and timeout, then a
  // mix of clean frames, cut frames, glitches, noise and idle stretches.
  task automatic run_setting();
    int                             bt;
    int                             hf;
    int                             r;
    int                             n;
    int                             start;
    logic [sbr_pkg::CFG_DATA_W-1:0] tmo;
    bt = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
    r  = $urandom_range(0, 9);
    if (r == 0) hf = 0;
    else if (r == 1) hf = $urandom_range(1, bt + 3);
    else hf = bt / 2;
    r = $urandom_range(0, 9);
    if (r < 2) tmo = sbr_pkg::CFG_DATA_W'($urandom_range(0, 3));
    else if (r < 8) tmo = sbr_pkg::CFG_DATA_W'($urandom_range(8, 150));
    else tmo = sbr_pkg::CFG_DATA_W'($urandom_range(400, 2000));
    // Random upper data bits must be dropped by the narrower registers.
    configure({4'($urandom_range(0, 15)), 16'(bt)}, {4'($urandom_range(0, 15)), 16'(hf)},
              {19'($urandom()), 1'($urandom_range(0, 1))}, tmo);
    if ($urandom_range(0, 3) == 0)
      write_reg(sbr_pkg::CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                sbr_pkg::CFG_DATA_W'($urandom()));
    n     = $urandom_range(80, 240);
    start = samples_sent;
    while (samples_sent - start < n) begin
      r = $urandom_range(0, 19);
      if (r < 13) begin
        send_frame(8'($urandom()), -1);
        send_idle($urandom_range(0, 2 * cur_bit + 2));
      end else if (r < 15) begin
        send_frame(8'($urandom()), $urandom_range(1, cur_half + 9 * cur_bit + 1));
      end else if (r < 17) begin
        repeat ($urandom_range(1, 12)) send_sample(1'($urandom_range(0, 1)));
      end else if (r == 17) begin
        send_sample(~line_idle);
        send_idle($urandom_range(1, 8));
      end else if (r == 18) begin
        send_idle($urandom_range(1, 60));
      end else begin
        // Pause the line until every word predicted so far has arrived.
        hold_input();
        drain_results();
      end
    end
    hold_input();
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bit_ticks masks to zero and half_bit_ticks is zero, so both
    // act as one tick; a write to an unused index must change nothing.
    configure(20'hF0000, 20'h00000, 20'hFFFFF, 20'd2);
    write_reg(sbr_pkg::CFG_INDEX_W'(CFG_FIRST_UNUSED + 1), 20'hFFFFF);
    // false start: line back at idle at the start check
    send_sample(1'b0);
    send_sample(1'b1);
    // idle timeout after the reload done by the false start
    send_idle(2);
    send_frame(8'hFF, -1);
    hold_input();
    drain_results();

    // Low idle level inverts the data; a zero timeout fires on every idle
    // sample once reloaded at the end of the frame.
    configure(20'd1, 20'd1, 20'd0, 20'd0);
    send_frame(8'h00, -1);
    send_idle(2);
    hold_input();
    drain_results();

    // Longest bit count and timeout, half-bit count with its upper bits
    // dropped: one slow false start, sent without gaps.
    configure(20'hFFFFF, 20'hF0100, 20'd0, 20'hFFFFF);
    calm_left = 300;
    send_sample(~line_idle);
    send_idle(260);
    calm_left = 0;
    hold_input();
    drain_results();

    samples_sent = 0;
    while (samples_sent < RANDOM_SAMPLES) run_setting();

    hold_input();
    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbr_pkg.sv
rtl/sbr_cfg.sv
rtl/sbr_core.sv
rtl/sbr_skid.sv
rtl/serial_byte_receiver.sv
tb/sv/tb_top.sv
